### src/ctt_pkg.sv
// Shared types and constants for the cooperative task timer table.
package ctt_pkg;

    // Input action codes
    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_ADD      = 2'd1,
        ACT_DISPATCH = 2'd2,
        ACT_DELETE   = 2'd3
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    localparam int TAG_W       = 8;
    localparam int TIME_W      = 32;
    localparam int RUNS_W      = 8;
    localparam int SN_W        = 3;
    localparam int IDX_W       = 4;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    // One task slot
    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] countdown;
        logic [TIME_W-1:0] period;
        logic [RUNS_W-1:0] pending;
    } slot_rec_t;

    // Command seen by the head update logic
    typedef struct packed {
        action_t           action;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] countdown;
        logic [TIME_W-1:0] period;
        logic              sel;
        logic              may_place;
        logic              may_dispatch;
    } head_cmd_t;

    // Events raised by the head update logic
    typedef struct packed {
        logic placed;
        logic dispatched;
        logic deleted_valid;
    } head_evt_t;

    // One result word
    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] slot_index;
        logic [TAG_W-1:0] run_tag;
        logic             last;
    } result_t;

endpackage

### src/ctt_div.sv
// Divider of a 32-bit value by the fixed tick length through reciprocal multiplication.
module ctt_div #(
    parameter int DIVISOR = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ctt_pkg::TIME_W-1:0] dividend,
    output logic                       busy,
    output logic [ctt_pkg::TIME_W-1:0] quotient
);
    import ctt_pkg::*;

    localparam int HALF_W   = TIME_W / 2;
    localparam int RECIP_SH = TIME_W + $clog2(DIVISOR);
    localparam int RECIP_W  = TIME_W + 1;
    localparam int PART_W   = HALF_W + RECIP_W;
    localparam int SUM_W    = TIME_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MUL,
        PH_SUM
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [TIME_W-1:0] x_reg, x_next;
    logic [PART_W-1:0] plo_reg, plo_next;
    logic [PART_W-1:0] phi_reg, phi_next;
    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  sum_sh;

    // Multiply both dividend halves by the reciprocal, then add and scale down
    always_comb
    begin
        sum        = {phi_reg, {HALF_W{1'b0}}} + SUM_W'(plo_reg);
        sum_sh     = sum >> RECIP_SH;
        phase_next = phase_reg;
        x_next     = x_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        quo_next   = quo_reg;
        case (phase_reg)
            PH_MUL:
            begin
                plo_next   = PART_W'(x_reg[HALF_W-1:0]) * PART_W'(RECIP);
                phi_next   = PART_W'(x_reg[TIME_W-1:HALF_W]) * PART_W'(RECIP);
                phase_next = PH_SUM;
            end
            PH_SUM:
            begin
                quo_next   = sum_sh[TIME_W-1:0];
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        if (start)
        begin
            x_next     = dividend;
            phase_next = PH_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            x_reg     <= '0;
            plo_reg   <= '0;
            phi_reg   <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            x_reg     <= x_next;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            quo_reg   <= quo_next;
        end
    end

    assign busy     = (phase_reg != PH_IDLE);
    assign quotient = quo_reg;

endmodule

### src/ctt_cell.sv
// One slot cell of the rotating slot chain.
module ctt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_en,
    input  ctt_pkg::slot_rec_t din,
    output ctt_pkg::slot_rec_t dout
);
    import ctt_pkg::*;

    slot_rec_t rec_reg, rec_next;

    // Take the neighbor's slot when the chain advances
    always_comb
    begin
        rec_next = shift_en ? din : rec_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_reg <= '0;
        else
            rec_reg <= rec_next;
    end

    assign dout = rec_reg;

endmodule

### src/ctt_head_update.sv
// Applies the current action to the slot at the head of the chain.
module ctt_head_update (
    input  ctt_pkg::head_cmd_t cmd,
    input  ctt_pkg::slot_rec_t head,
    output ctt_pkg::slot_rec_t rec_next,
    output ctt_pkg::head_evt_t evt
);
    import ctt_pkg::*;

    always_comb
    begin
        rec_next = head;
        evt      = '0;
        case (cmd.action)
            ACT_TICK:
            begin
                // Count down, or at zero fire and reload periodic slots
                if (head.valid)
                begin
                    if (head.countdown == '0)
                    begin
                        if (head.pending != '1)
                            rec_next.pending = head.pending + 1'b1;
                        if (head.period != '0)
                            rec_next.countdown = head.period;
                    end
                    else
                    begin
                        rec_next.countdown = head.countdown - 1'b1;
                    end
                end
            end
            ACT_ADD:
            begin
                // Fill the first free slot
                if (cmd.may_place && !head.valid)
                begin
                    rec_next.valid     = 1'b1;
                    rec_next.tag       = cmd.tag;
                    rec_next.countdown = cmd.countdown;
                    rec_next.period    = cmd.period;
                    rec_next.pending   = '0;
                    evt.placed         = 1'b1;
                end
            end
            ACT_DISPATCH:
            begin
                // Take one run off; free one-shot slots
                if (cmd.may_dispatch && head.pending != '0)
                begin
                    evt.dispatched   = 1'b1;
                    rec_next.pending = head.pending - 1'b1;
                    if (head.period == '0)
                        rec_next = '0;
                end
            end
            ACT_DELETE:
            begin
                if (cmd.sel)
                begin
                    evt.deleted_valid = head.valid;
                    rec_next          = '0;
                end
            end
            default:
            begin
                rec_next = head;
            end
        endcase
    end

endmodule

### src/cooperative_task_timer_table_core.sv
// Top level of the cooperative task timer table.
// The slot table is a ring of SLOT_COUNT cells that rotates one slot per cycle past a
// single update head, so every action visits the slots in order, lowest first. A tick,
// a dispatch or a delete is accepted, steps the ring once per slot and then posts the
// closing word; an add first waits on two dividers that turn the delay and the period
// into ticks by multiplying with the reciprocal of the tick length. The rotation pauses
// whenever a result word is waiting and the output side is not ready. A new input word
// is taken only when the previous one is finished, while its last result may still wait
// in the output register. Dispatch returns up to eight words, one per slot with pending
// runs; every other action returns one word.
module cooperative_task_timer_table_core #(
    parameter int SLOT_COUNT = 8,
    parameter int TICK_MS    = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // task_tag[7:0], delay_ms[39:8], period_ms[71:40], slot_number[74:72], zeros
    input  logic [79:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot_index[3:0], run_tag[11:4], zeros
    output logic [15:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import ctt_pkg::*;

    localparam int STEP_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SLOT_COUNT - 1);
    localparam logic [IDX_W-1:0]  FULL_IDX  = IDX_W'(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SWEEP,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    action_t            action_reg, action_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [SN_W-1:0]    sn_reg, sn_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               placed_reg, placed_next;
    logic [STEP_W-1:0]  place_idx_reg, place_idx_next;
    logic               was_valid_reg, was_valid_next;
    logic [CNT_W-1:0]   found_reg, found_next;
    logic               held_valid_reg, held_valid_next;
    result_t            held_reg, held_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               in_take;
    logic               out_free;
    logic               advance;
    logic               div_start;
    logic               delay_busy, period_busy;
    logic [TIME_W-1:0]  delay_q, period_q;
    logic [STEP_W+IDX_W-1:0] step_ext;
    logic [STEP_W+IDX_W-1:0] place_ext;
    logic [STEP_W+SN_W-1:0]  step_cmp, sn_cmp;
    head_cmd_t          cmd;
    head_evt_t          evt;
    slot_rec_t          head_next;
    slot_rec_t          chain [SLOT_COUNT];

    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign advance   = (state_reg == S_SWEEP) && out_free;
    assign div_start = in_take && (action_t'(s_axis_tuser) == ACT_ADD);

    // Convert milliseconds to ticks
    ctt_div #(.DIVISOR(TICK_MS)) u_div_delay (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (s_axis_tdata[39:8]),
        .busy     (delay_busy),
        .quotient (delay_q)
    );

    ctt_div #(.DIVISOR(TICK_MS)) u_div_period (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (s_axis_tdata[71:40]),
        .busy     (period_busy),
        .quotient (period_q)
    );

    // Index arithmetic at fixed widths
    assign step_ext  = {{IDX_W{1'b0}}, step_reg};
    assign place_ext = {{IDX_W{1'b0}}, place_idx_reg};
    assign step_cmp  = {{SN_W{1'b0}}, step_reg};
    assign sn_cmp    = {{STEP_W{1'b0}}, sn_reg};

    // Build the head command
    always_comb
    begin
        cmd.action       = action_reg;
        cmd.tag          = tag_reg;
        cmd.countdown    = delay_q;
        cmd.period       = period_q;
        cmd.sel          = (step_cmp == sn_cmp);
        cmd.may_place    = !placed_reg;
        cmd.may_dispatch = (found_reg < CNT_W'(MAX_RESULTS));
    end

    ctt_head_update u_head (
        .cmd      (cmd),
        .head     (chain[0]),
        .rec_next (head_next),
        .evt      (evt)
    );

    // Slot ring: the updated head re-enters at the tail
    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++)
        begin : g_cell
            if (gi == SLOT_COUNT - 1)
            begin : g_tail
                ctt_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (advance),
                    .din      (head_next),
                    .dout     (chain[gi])
                );
            end
            else
            begin : g_body
                ctt_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (advance),
                    .din      (chain[gi+1]),
                    .dout     (chain[gi])
                );
            end
        end
    endgenerate

    // Sequencer and result path
    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        tag_next        = tag_reg;
        sn_next         = sn_reg;
        step_next       = step_reg;
        placed_next     = placed_reg;
        place_idx_next  = place_idx_reg;
        was_valid_next  = was_valid_reg;
        found_next      = found_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_next        = out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    action_next     = action_t'(s_axis_tuser);
                    tag_next        = s_axis_tdata[7:0];
                    sn_next         = s_axis_tdata[74:72];
                    step_next       = '0;
                    placed_next     = 1'b0;
                    place_idx_next  = '0;
                    was_valid_next  = 1'b0;
                    found_next      = '0;
                    held_valid_next = 1'b0;
                    state_next      = (action_t'(s_axis_tuser) == ACT_ADD) ? S_DIV : S_SWEEP;
                end
            end
            S_DIV:
            begin
                if (!delay_busy && !period_busy)
                    state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (advance)
                begin
                    if (evt.placed)
                    begin
                        placed_next    = 1'b1;
                        place_idx_next = step_reg;
                    end
                    if (evt.deleted_valid)
                        was_valid_next = 1'b1;
                    if (evt.dispatched)
                    begin
                        // Release the previous hit, it is not the last
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = held_reg;
                        end
                        held_valid_next      = 1'b1;
                        held_next.status     = ST_OK;
                        held_next.slot_index = step_ext[IDX_W-1:0];
                        held_next.run_tag    = chain[0].tag;
                        held_next.last       = 1'b0;
                        found_next           = found_reg + 1'b1;
                    end
                    if (step_reg == STEP_LAST)
                        state_next = S_FINISH;
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.status     = ST_OK;
                    out_next.slot_index = '0;
                    out_next.run_tag    = '0;
                    out_next.last       = 1'b1;
                    case (action_reg)
                        ACT_ADD:
                        begin
                            if (placed_reg)
                                out_next.slot_index = place_ext[IDX_W-1:0];
                            else
                            begin
                                out_next.status     = ST_FULL;
                                out_next.slot_index = FULL_IDX;
                            end
                        end
                        ACT_DISPATCH:
                        begin
                            if (held_valid_reg)
                            begin
                                out_next      = held_reg;
                                out_next.last = 1'b1;
                            end
                            else
                                out_next.status = ST_NONE;
                        end
                        ACT_DELETE:
                        begin
                            out_next.status     = was_valid_reg ? ST_OK : ST_EMPTY;
                            out_next.slot_index = IDX_W'(sn_reg);
                        end
                        default:
                        begin
                            out_next.status = ST_OK;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            action_reg     <= ACT_TICK;
            step_reg       <= '0;
            placed_reg     <= 1'b0;
            was_valid_reg  <= 1'b0;
            found_reg      <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            action_reg     <= action_next;
            step_reg       <= step_next;
            placed_reg     <= placed_next;
            was_valid_reg  <= was_valid_next;
            found_reg      <= found_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tag_reg       <= tag_next;
        sn_reg        <= sn_next;
        place_idx_reg <= place_idx_next;
        held_reg      <= held_next;
        out_reg       <= out_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_reg.run_tag, out_reg.slot_index};
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.last;

    // Checks
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) && (action_reg == ACT_ADD) |-> !delay_busy && !period_busy)
        else $error("slot sweep started before division finished");

    a_found_cap: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= CNT_W'(MAX_RESULTS))
        else $error("dispatch exceeded result cap");

    a_held_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg && (state_reg != S_IDLE) |-> (action_reg == ACT_DISPATCH))
        else $error("held result outside dispatch");

endmodule

### verif/tb_cooperative_task_timer_table_core.sv
// Self-checking testbench for the cooperative task timer table core.
module tb_cooperative_task_timer_table_core;
    import ctt_pkg::*;

    localparam int SLOTS   = 8;
    localparam int TICK_LEN = 10;

    // Slot table predictor plus the queue of result words still owed by the block
    class timer_table_tracker;
        bit          slot_used [SLOTS];
        logic [7:0]  slot_tag  [SLOTS];
        logic [31:0] slot_left [SLOTS];
        logic [31:0] slot_reload [SLOTS];
        logic [7:0]  slot_runs [SLOTS];
        result_t     owed_words [$];
        int          mismatch_count;

        function new();
            for (int s = 0; s < SLOTS; s++)
                free_slot(s);
            mismatch_count = 0;
        endfunction

        function void free_slot(int s);
            slot_used[s]   = 1'b0;
            slot_tag[s]    = '0;
            slot_left[s]   = '0;
            slot_reload[s] = '0;
            slot_runs[s]   = '0;
        endfunction

        function void owe(status_t st, int idx, logic [7:0] tg, logic lst);
            result_t r;
            r.status     = st;
            r.slot_index = IDX_W'(idx);
            r.run_tag    = tg;
            r.last       = lst;
            owed_words.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        // Apply one accepted input word to the slot table and queue its results
        function void note_input(action_t act, logic [7:0] tg, logic [31:0] dly,
                                 logic [31:0] per, logic [2:0] sn);
            int s;
            int n;
            n = 0;
            case (act)
                ACT_TICK:
                begin
                    for (s = 0; s < SLOTS; s++)
                    begin
                        if (!slot_used[s])
                            continue;
                        if (slot_left[s] == 0)
                        begin
                            if (slot_runs[s] != 8'hFF)
                                slot_runs[s]++;
                            if (slot_reload[s] != 0)
                                slot_left[s] = slot_reload[s];
                        end
                        else
                            slot_left[s]--;
                    end
                    owe(ST_OK, 0, 8'h00, 1'b1);
                end
                ACT_ADD:
                begin
                    for (s = 0; s < SLOTS; s++)
                        if (!slot_used[s])
                            break;
                    if (s == SLOTS)
                        owe(ST_FULL, SLOTS, 8'h00, 1'b1);
                    else
                    begin
                        slot_used[s]   = 1'b1;
                        slot_tag[s]    = tg;
                        slot_left[s]   = dly / TICK_LEN;
                        slot_reload[s] = per / TICK_LEN;
                        slot_runs[s]   = '0;
                        owe(ST_OK, s, 8'h00, 1'b1);
                    end
                end
                ACT_DISPATCH:
                begin
                    for (s = 0; s < SLOTS && n < MAX_RESULTS; s++)
                    begin
                        if (slot_runs[s] == 0)
                            continue;
                        owe(ST_OK, s, slot_tag[s], 1'b0);
                        n++;
                        slot_runs[s]--;
                        // one-shot slots leave the table on their first run
                        if (slot_reload[s] == 0)
                            free_slot(s);
                    end
                    if (n == 0)
                        owe(ST_NONE, 0, 8'h00, 1'b1);
                    else
                        owed_words[owed_words.size() - 1].last = 1'b1;
                end
                default:
                begin
                    if (int'(sn) >= SLOTS)
                        owe(ST_EMPTY, sn, 8'h00, 1'b1);
                    else
                    begin
                        owe(slot_used[sn] ? ST_OK : ST_EMPTY, sn, 8'h00, 1'b1);
                        free_slot(sn);
                    end
                end
            endcase
        endfunction

        // Compare one result word with the oldest owed word
        task check_result(result_t got);
            result_t want;
            if (owed_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word status %0d slot %0d tag %0d",
                                          got.status, got.slot_index, got.run_tag));
                return;
            end
            want = owed_words.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.slot_index !== want.slot_index)
                report_mismatch($sformatf("slot_index %0d, want %0d",
                                          got.slot_index, want.slot_index));
            if (got.run_tag !== want.run_tag)
                report_mismatch($sformatf("run_tag %0d, want %0d", got.run_tag, want.run_tag));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    timer_table_tracker tracker;
    bit sender_steady = 1'b0;
    bit hold_req = 1'b0;

    cooperative_task_timer_table_core #(
        .SLOT_COUNT(SLOTS),
        .TICK_MS   (TICK_LEN)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task send_word(action_t act, logic [7:0] tg, logic [31:0] dly, logic [31:0] per,
                   logic [2:0] sn);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {5'b0, sn, per, dly, tg};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_input(act, tg, dly, per, sn);
    endtask

    // Millisecond value: mostly a few ticks, sometimes wider, sometimes any 32 bits
    function automatic logic [31:0] pick_ms(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return 32'd0;
        else if (r < 75)
            return $urandom_range(0, 60);
        else if (r < 90)
            return $urandom_range(0, 300);
        else
            return $urandom();
    endfunction

    task send_random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_word(ACT_TICK, 8'($urandom()), $urandom(), $urandom(), 3'($urandom()));
        else if (r < 60)
            send_word(ACT_ADD, 8'($urandom()), pick_ms(10), pick_ms(30), 3'($urandom()));
        else if (r < 82)
            send_word(ACT_DISPATCH, 8'($urandom()), $urandom(), $urandom(),
                      3'($urandom()));
        else
            send_word(ACT_DELETE, 8'($urandom()), $urandom(), $urandom(),
                      3'($urandom_range(0, 7)));
    endtask

    // Result side: random ready gaps, steady stretches and one long hold-off
    initial
    begin : result_side
        int gap_left;
        int steady_left;
        int hold_left;
        int r;
        bit hold_done;
        gap_left = 0;
        steady_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end
            else if (steady_left > 0)
            begin
                steady_left--;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    steady_left = $urandom_range(20, 80);
                else if (r < 65)
                    gap_left = 0;
                else if (r < 95)
                    gap_left = $urandom_range(1, 3);
                else
                    gap_left = $urandom_range(10, 40);
                if (gap_left > 0)
                    gap_left--;
                m_axis_tready <= (r < 65);
            end
        end
    end

    // Check every accepted result word
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result({m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[11:4],
                                  m_axis_tlast});
    end

    initial
    begin : stimulus
        int i;
        tracker = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, one-shot at zero, full table, deletes
        send_word(ACT_TICK, 8'h00, 32'd0, 32'd0, 3'd0);
        send_word(ACT_DISPATCH, 8'h00, 32'd0, 32'd0, 3'd0);
        send_word(ACT_DELETE, 8'h00, 32'd0, 32'd0, 3'd0);
        send_word(ACT_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        send_word(ACT_ADD, 8'h00, 32'd0, 32'd0, 3'd0);
        send_word(ACT_ADD, 8'hA5, 32'd9, 32'd25, 3'd0);
        send_word(ACT_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        send_word(ACT_TICK, 8'h00, 32'd0, 32'd0, 3'd0);
        send_word(ACT_DISPATCH, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        send_word(ACT_DISPATCH, 8'h00, 32'd0, 32'd0, 3'd0);
        for (i = 0; i < 6; i++)
            send_word(ACT_ADD, 8'(8'h10 + i), 32'(i * 10), 32'(i * 7), 3'd0);
        send_word(ACT_ADD, 8'h5A, 32'd10, 32'd10, 3'd0);
        send_word(ACT_DELETE, 8'h00, 32'd0, 32'd0, 3'd7);
        send_word(ACT_DELETE, 8'h00, 32'd0, 32'd0, 3'd7);
        send_word(ACT_DELETE, 8'h00, 32'd0, 32'd0, 3'd0);
        send_word(ACT_TICK, 8'h00, 32'd0, 32'd0, 3'd0);
        send_word(ACT_DISPATCH, 8'h00, 32'd0, 32'd0, 3'd0);

        // Saturate pending runs: clear the table, park a one-shot at zero, tick past 255
        for (i = 0; i < SLOTS; i++)
            send_word(ACT_DELETE, 8'($urandom()), $urandom(), $urandom(), 3'(i));
        send_word(ACT_ADD, 8'hC3, 32'd5, 32'd0, 3'd0);
        send_word(ACT_ADD, 8'h3C, 32'd0, 32'd10, 3'd0);
        sender_steady = 1'b1;
        for (i = 0; i < 262; i++)
            send_word(ACT_TICK, 8'($urandom()), $urandom(), $urandom(), 3'($urandom()));
        sender_steady = 1'b0;
        send_word(ACT_DISPATCH, 8'h00, 32'd0, 32'd0, 3'd0);
        send_word(ACT_DISPATCH, 8'h00, 32'd0, 32'd0, 3'd0);
        send_word(ACT_DISPATCH, 8'h00, 32'd0, 32'd0, 3'd0);

        // Random traffic; one steady stretch runs against the long result hold-off
        for (i = 0; i < 100; i++)
        begin
            if (i == 30)
            begin
                hold_req = 1'b1;
                sender_steady = 1'b1;
            end
            else if (i == 80)
                sender_steady = 1'b0;
            send_random_word();
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then let the block settle
        while (tracker.owed_words.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.owed_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
